// ===== rtl/tstg_pkg.sv =====
package tstg_pkg;

  localparam int COORD_BITS = 16;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int CMP_BITS   = 17;

  localparam logic [2:0] REQ_HW_UP    = 3'd0;
  localparam logic [2:0] REQ_HW_DOWN  = 3'd1;
  localparam logic [2:0] REQ_HW_LEFT  = 3'd2;
  localparam logic [2:0] REQ_HW_RIGHT = 3'd3;
  localparam logic [2:0] REQ_X        = 3'd4;
  localparam logic [2:0] REQ_Y        = 3'd5;
  localparam logic [2:0] REQ_TOUCH    = 3'd6;

  localparam logic [2:0] GEST_UP    = 3'd0;
  localparam logic [2:0] GEST_DOWN  = 3'd1;
  localparam logic [2:0] GEST_LEFT  = 3'd2;
  localparam logic [2:0] GEST_RIGHT = 3'd3;
  localparam logic [2:0] GEST_DTAP  = 3'd4;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SWIPE_TH  = 2'd0;
  localparam cfg_idx_t CFG_TAP_TH    = 2'd1;
  localparam cfg_idx_t CFG_DTAP_WIN  = 2'd2;
  localparam cfg_idx_t CFG_COOLDOWN  = 2'd3;

  localparam logic [14:0] SWIPE_TH_RST = 15'd30;
  localparam logic [14:0] TAP_TH_RST   = 15'd10;
  localparam logic [15:0] DTAP_WIN_RST = 16'd350;
  localparam logic [15:0] COOLDOWN_RST = 16'd400;

endpackage

// ===== rtl/touch_swipe_tap_gesture_detector_top.sv =====
// Touch gesture detector. Each transfer on the input channel carries one panel
// event (hardware swipe key, X or Y coordinate, or touch press/release) with its
// millisecond timestamp. The event is evaluated in the cycle it is accepted:
// coordinates, start point, flags and timestamps update at that edge, and a
// gesture, if any, lands in the output register on the same edge. One event is
// taken every cycle; the only stall is a held gesture in the output register
// that the consumer has not taken. The user must write thresholds and time
// windows via the config channel while the block is idle (not enforced here);
// reports within cooldown_ms of the last one, or with ui_busy set, are dropped.
module touch_swipe_tap_gesture_detector_top
  import tstg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [15:0] value,
  input  logic [31:0] now_ms,
  input  logic        ui_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  gesture,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  logic [14:0] swipe_min;
  logic [14:0] tap_threshold;
  logic [15:0] double_tap_window_ms;
  logic [15:0] cooldown_ms;

  logic [COORD_BITS-1:0] cur_x, cur_y, start_x, start_y;
  logic                  touch_prev, tracking, hw_raised;
  logic [31:0]           last_gesture_ms, last_tap_ms;

  logic                  in_fire;
  logic                  hw_act, active, rel;
  logic signed [DELTA_BITS-1:0] dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0] ax, ay;
  logic [CMP_BITS-1:0]   ax_c, ay_c, swth_c, tapth_c;
  logic                  swipe_v, swipe_h, tap_ok, dbl;
  logic [31:0]           since_gest, since_tap;
  logic                  gate_ok, cand, emit;
  logic [2:0]            code;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign hw_act = (req_type <= REQ_HW_RIGHT) && (value == 16'd1);
  assign active = (value != 16'd0);
  assign rel    = (req_type == REQ_TOUCH) && !active && !hw_raised && tracking;

  // axis-swapped movement: display x follows panel y, display y is inverted panel x
  assign dx     = $signed({1'b0, cur_y}) - $signed({1'b0, start_y});
  assign dy     = $signed({1'b0, start_x}) - $signed({1'b0, cur_x});
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = COORD_BITS'(dx[DELTA_BITS-1] ? dx_neg : dx);
  assign ay     = COORD_BITS'(dy[DELTA_BITS-1] ? dy_neg : dy);

  assign ax_c    = CMP_BITS'(ax);
  assign ay_c    = CMP_BITS'(ay);
  assign swth_c  = CMP_BITS'(swipe_min);
  assign tapth_c = CMP_BITS'(tap_threshold);

  assign swipe_v = (ay_c > ax_c) && (ay_c > swth_c);
  assign swipe_h = (ax_c > ay_c) && (ax_c > swth_c);
  assign tap_ok  = !swipe_v && !swipe_h && (ax_c <= tapth_c) && (ay_c <= tapth_c);

  assign since_gest = now_ms - last_gesture_ms;
  assign since_tap  = now_ms - last_tap_ms;
  assign dbl        = tap_ok && (last_tap_ms != 32'd0) &&
                      (since_tap < {16'd0, double_tap_window_ms});
  assign gate_ok    = (since_gest >= {16'd0, cooldown_ms}) && !ui_busy;

  always_comb begin
    cand = 1'b0;
    code = GEST_UP;
    if (hw_act) begin
      cand = 1'b1;
      code = req_type;
    end else if (rel) begin
      if (swipe_v) begin
        cand = 1'b1;
        code = dy[DELTA_BITS-1] ? GEST_UP : GEST_DOWN;
      end else if (swipe_h) begin
        cand = 1'b1;
        code = dx[DELTA_BITS-1] ? GEST_LEFT : GEST_RIGHT;
      end else if (dbl) begin
        cand = 1'b1;
        code = GEST_DTAP;
      end
    end
  end

  assign emit = in_fire && cand && gate_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_min            <= SWIPE_TH_RST;
      tap_threshold        <= TAP_TH_RST;
      double_tap_window_ms <= DTAP_WIN_RST;
      cooldown_ms          <= COOLDOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SWIPE_TH: swipe_min            <= cfg_data[14:0];
        CFG_TAP_TH:   tap_threshold        <= cfg_data[14:0];
        CFG_DTAP_WIN: double_tap_window_ms <= cfg_data;
        CFG_COOLDOWN: cooldown_ms          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x           <= '0;
      cur_y           <= '0;
      start_x         <= '0;
      start_y         <= '0;
      touch_prev      <= 1'b0;
      tracking        <= 1'b0;
      hw_raised       <= 1'b0;
      last_gesture_ms <= '0;
      last_tap_ms     <= '0;
    end else if (in_fire) begin
      if (emit) last_gesture_ms <= now_ms;
      if (hw_act) hw_raised <= 1'b1;
      if (req_type == REQ_X) cur_x <= value[COORD_BITS-1:0];
      if (req_type == REQ_Y) cur_y <= value[COORD_BITS-1:0];
      if (req_type == REQ_TOUCH) begin
        touch_prev <= active;
        if (active && !touch_prev) begin
          start_x   <= cur_x;
          start_y   <= cur_y;
          tracking  <= 1'b1;
          hw_raised <= 1'b0;
        end else if (!active) begin
          tracking  <= 1'b0;
          hw_raised <= 1'b0;
          // a double tap clears the pending tap even when its report is dropped
          if (rel && dbl) last_tap_ms <= '0;
          else if (rel && tap_ok) last_tap_ms <= now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) gesture <= code;
  end

`ifndef SYNTH
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && ui_busy) |-> !emit)
    else $error("gesture emitted while ui busy");

  a_gest_stamp: assert property (@(posedge clk) disable iff (rst)
    emit |=> (last_gesture_ms == $past(now_ms)))
    else $error("report time not recorded");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture <= GEST_DTAP))
    else $error("gesture code out of range");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && gesture == $past(code)))
    else $error("emitted gesture not loaded");
`endif

endmodule
